>>> rtl/sara_pkg.sv
// ----------------------------------------------------------------------------
// sara_pkg: shared types and constants of the surface area ratio accumulator
// Beat formats, window geometry tables and datapath widths.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package sara_pkg;

    // Field and datapath widths
    localparam int HEIGHT_W        = 16;
    localparam int MASK_W          = 9;
    localparam int NUM_CELLS       = 9;
    localparam int CELL_SIZE_W     = 16;
    localparam int IDX_W           = 16;
    localparam int REGION_CNT_W    = 16;
    localparam int C2_W            = 2 * CELL_SIZE_W;
    localparam int RAD_W           = 42;
    localparam int ROOT_W          = RAD_W / 2;
    localparam int HALF_W          = 19;
    localparam int ACC_W           = 45;
    localparam int AREA_SHIFT      = 4;
    localparam int AREA_W          = ACC_W - AREA_SHIFT;
    localparam int REGION_SUM_W    = 48;
    localparam int TOTAL_SUM_W     = 64;
    localparam int IDX_SHIFT       = 8;
    localparam int NUM_EDGES       = 16;
    localparam int NUM_TRIS        = 8;
    localparam int QUEUE_DEPTH     = 2;
    localparam int COUNT_WIDTH_DEF = 32;

    localparam logic [CELL_SIZE_W-1:0] CELL_SIZE_RESET = 16'd2560;

    // Edge endpoints as window cell numbers
    // Cell order: center, N, E, W, S, NE, NW, SE, SW
    localparam logic [3:0] EDGE_P [NUM_EDGES] = '{
        4'd6, 4'd1, 4'd3, 4'd0, 4'd8, 4'd4, 4'd6, 4'd1,
        4'd5, 4'd3, 4'd0, 4'd2, 4'd0, 4'd0, 4'd0, 4'd0
    };
    localparam logic [3:0] EDGE_Q [NUM_EDGES] = '{
        4'd1, 4'd5, 4'd0, 4'd2, 4'd4, 4'd7, 4'd3, 4'd0,
        4'd2, 4'd8, 4'd4, 4'd7, 4'd6, 4'd5, 4'd8, 4'd7
    };
    // the last edges in the table, those set in EDGE_DIAG, run from the center to the corners
    localparam logic [NUM_EDGES-1:0] EDGE_DIAG = 16'hF000;

    // Triangle sides as edge numbers
    localparam logic [3:0] TRI_A [NUM_TRIS] = '{
        4'd12, 4'd7, 4'd6, 4'd13, 4'd2, 4'd3, 4'd14, 4'd10
    };
    localparam logic [3:0] TRI_B [NUM_TRIS] = '{
        4'd0, 4'd1, 4'd2, 4'd8, 4'd9, 4'd11, 4'd10, 4'd15
    };
    localparam logic [3:0] TRI_C [NUM_TRIS] = '{
        4'd7, 4'd13, 4'd12, 4'd3, 4'd14, 4'd15, 4'd4, 4'd5
    };

    // Input beat
    typedef struct packed {
        logic [HEIGHT_W-1:0] height_center;
        logic [HEIGHT_W-1:0] height_north;
        logic [HEIGHT_W-1:0] height_east;
        logic [HEIGHT_W-1:0] height_west;
        logic [HEIGHT_W-1:0] height_south;
        logic [HEIGHT_W-1:0] height_northeast;
        logic [HEIGHT_W-1:0] height_northwest;
        logic [HEIGHT_W-1:0] height_southeast;
        logic [HEIGHT_W-1:0] height_southwest;
        logic [MASK_W-1:0]   valid_mask;
        logic                region_end;
        logic                map_end;
    } pixel_t;

    // Output beat
    typedef struct packed {
        logic [IDX_W-1:0]        region_index;
        logic [REGION_CNT_W-1:0] region_pixels;
        logic [IDX_W-1:0]        landscape_index;
        logic                    map_done;
    } result_t;

    // Classified queue entry
    typedef struct packed {
        logic [NUM_CELLS-1:0][HEIGHT_W-1:0] heights;
        logic                               full;
        logic                               emit;
        logic                               map_end;
    } work_t;

    // Square root unit handshake
    typedef struct packed {
        logic             start;
        logic [RAD_W-1:0] radicand;
    } sqrt_req_t;

    typedef struct packed {
        logic              done;
        logic [ROOT_W-1:0] root;
    } sqrt_rsp_t;

    // Ratio unit result
    typedef struct packed {
        logic             done;
        logic [IDX_W-1:0] index;
    } div_rsp_t;

endpackage

>>> rtl/sara_front.sv
// ----------------------------------------------------------------------------
// sara_front: input classifier and work queue
// Takes pixel beats, marks complete windows and region closes, and holds
// them in a short queue for the back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sara_front (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             pixel_valid,
    output logic             pixel_stall,
    input  sara_pkg::pixel_t pixel,
    output logic             work_valid,
    output sara_pkg::work_t  work,
    input  logic             work_pop
);
    import sara_pkg::*;

    localparam int PTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);

    work_t              queue_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [FILL_W-1:0]  fill_reg;
    work_t              entry;
    logic               push;
    logic               pop;

    // Classify the incoming beat
    always_comb
    begin
        entry.heights[0] = pixel.height_center;
        entry.heights[1] = pixel.height_north;
        entry.heights[2] = pixel.height_east;
        entry.heights[3] = pixel.height_west;
        entry.heights[4] = pixel.height_south;
        entry.heights[5] = pixel.height_northeast;
        entry.heights[6] = pixel.height_northwest;
        entry.heights[7] = pixel.height_southeast;
        entry.heights[8] = pixel.height_southwest;
        entry.full       = &pixel.valid_mask;
        entry.emit       = pixel.region_end | pixel.map_end;
        entry.map_end    = pixel.map_end;
    end

    assign pixel_stall = (fill_reg == FILL_W'(QUEUE_DEPTH));
    assign push        = pixel_valid & ~pixel_stall;
    assign work_valid  = (fill_reg != '0);
    assign pop         = work_pop & work_valid;
    assign work        = queue_mem[rd_ptr_reg];

    // Queue storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            queue_mem[wr_ptr_reg] <= entry;
        end
    end

    // Queue pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                     : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                     : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                fill_reg <= fill_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                fill_reg <= fill_reg - 1'b1;
            end
        end
    end

endmodule

>>> rtl/sara_sqrt.sv
// ----------------------------------------------------------------------------
// sara_sqrt: iterative integer square root
// Digit-by-digit restoring root, one result bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sara_sqrt (
    input  logic                clk,
    input  logic                rst_n,
    input  sara_pkg::sqrt_req_t req,
    output sara_pkg::sqrt_rsp_t rsp
);
    import sara_pkg::*;

    localparam int STEP_W = $clog2(ROOT_W);

    logic               busy_reg;
    logic               done_reg;
    logic [STEP_W-1:0]  step_reg;
    logic [RAD_W-1:0]   n_reg;
    logic [ROOT_W:0]    rem_reg;
    logic [ROOT_W-1:0]  root_reg;
    logic [ROOT_W+2:0]  rem_sh;
    logic [ROOT_W+2:0]  trial;
    logic               fits;

    // One trial subtraction per cycle
    always_comb
    begin
        rem_sh = {rem_reg, n_reg[RAD_W-1 -: 2]};
        trial  = {1'b0, root_reg, 2'b01};
        fits   = (rem_sh >= trial);
    end

    assign rsp.done = done_reg;
    assign rsp.root = root_reg;

    // Control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                step_reg <= STEP_W'(ROOT_W - 1);
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg - 1'b1;
                if (step_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            n_reg    <= req.radicand;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (busy_reg)
        begin
            n_reg <= {n_reg[RAD_W-3:0], 2'b00};
            if (fits)
            begin
                // remainder can reach twice the root, one bit over the root width
                rem_reg  <= (ROOT_W+1)'(rem_sh - trial);
                root_reg <= {root_reg[ROOT_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg  <= rem_sh[ROOT_W:0];
                root_reg <= {root_reg[ROOT_W-2:0], 1'b0};
            end
        end
    end

endmodule

>>> rtl/sara_div.sv
// ----------------------------------------------------------------------------
// sara_div: saturating Q8.8 ratio unit
// index = min(0xFFFF, floor(sum * 256 / (count * c2))), zero for an empty
// count. Shift-add product over the count bits, then restoring division.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sara_div #(
    parameter int COUNT_WIDTH = sara_pkg::COUNT_WIDTH_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    input  logic [sara_pkg::TOTAL_SUM_W-1:0] sum,
    input  logic [COUNT_WIDTH-1:0]           count,
    input  logic [sara_pkg::C2_W-1:0]        c2,
    output sara_pkg::div_rsp_t               rsp
);
    import sara_pkg::*;

    localparam int DEN_W  = COUNT_WIDTH + C2_W;
    localparam int QBITS  = IDX_W + 1;
    localparam int NUM_W  = TOTAL_SUM_W + IDX_SHIFT;
    localparam int DSH_W  = DEN_W + QBITS - 1;
    localparam int CMP_W  = (DSH_W > NUM_W) ? DSH_W : NUM_W;
    localparam int MCNT_W = $clog2(COUNT_WIDTH);
    localparam int QCNT_W = $clog2(QBITS);

    typedef enum logic [1:0] {
        D_IDLE,
        D_MUL,
        D_DIV
    } div_state_t;

    div_state_t          state_reg;
    logic                done_reg;
    logic [IDX_W-1:0]    index_reg;
    logic [MCNT_W-1:0]   mcnt_reg;
    logic [QCNT_W-1:0]   qcnt_reg;
    logic [COUNT_WIDTH-1:0] cnt_sh_reg;
    logic [C2_W-1:0]     c2_reg;
    logic [DEN_W-1:0]    den_reg;
    logic [CMP_W-1:0]    rem_reg;
    logic [CMP_W-1:0]    dsh_reg;
    logic [QBITS-1:0]    q_reg;
    logic [DEN_W-1:0]    den_next;
    logic                fits;
    logic [QBITS-1:0]    q_next;

    // Shift-add step and division step
    always_comb
    begin
        den_next = {den_reg[DEN_W-2:0], 1'b0}
                 + (cnt_sh_reg[COUNT_WIDTH-1] ? DEN_W'(c2_reg) : '0);
        fits     = (rem_reg >= dsh_reg);
        q_next   = {q_reg[QBITS-2:0], fits};
    end

    assign rsp.done  = done_reg;
    assign rsp.index = index_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= D_IDLE;
            done_reg  <= 1'b0;
            index_reg <= '0;
            mcnt_reg  <= '0;
            qcnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                D_IDLE:
                begin
                    if (start)
                    begin
                        if (count == '0)
                        begin
                            done_reg  <= 1'b1;
                            index_reg <= '0;
                        end
                        else
                        begin
                            mcnt_reg  <= MCNT_W'(COUNT_WIDTH - 1);
                            state_reg <= D_MUL;
                        end
                    end
                end
                D_MUL:
                begin
                    mcnt_reg <= mcnt_reg - 1'b1;
                    if (mcnt_reg == '0)
                    begin
                        qcnt_reg  <= QCNT_W'(QBITS - 1);
                        state_reg <= D_DIV;
                    end
                end
                D_DIV:
                begin
                    qcnt_reg <= qcnt_reg - 1'b1;
                    if (qcnt_reg == '0)
                    begin
                        done_reg  <= 1'b1;
                        index_reg <= q_next[QBITS-1] ? '1 : q_next[IDX_W-1:0];
                        state_reg <= D_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= D_IDLE;
                end
            endcase
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        if (state_reg == D_IDLE && start)
        begin
            cnt_sh_reg <= count;
            c2_reg     <= c2;
            den_reg    <= '0;
            rem_reg    <= CMP_W'({sum, {IDX_SHIFT{1'b0}}});
            q_reg      <= '0;
        end
        else if (state_reg == D_MUL)
        begin
            den_reg    <= den_next;
            cnt_sh_reg <= {cnt_sh_reg[COUNT_WIDTH-2:0], 1'b0};
            dsh_reg    <= CMP_W'({den_next, {(QBITS-1){1'b0}}});
        end
        else if (state_reg == D_DIV)
        begin
            if (fits)
            begin
                rem_reg <= rem_reg - dsh_reg;
            end
            dsh_reg <= {1'b0, dsh_reg[CMP_W-1:1]};
            q_reg   <= q_next;
        end
    end

endmodule

>>> rtl/sara_back.sv
// ----------------------------------------------------------------------------
// sara_back: window area sequencer and region accumulators
// Runs the sixteen half edges and eight triangles of a complete window
// through one shared root unit, keeps the sums, and at a region close
// forms both indices in the ratio unit and loads the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sara_back #(
    parameter int COUNT_WIDTH = sara_pkg::COUNT_WIDTH_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             work_valid,
    input  sara_pkg::work_t                  work,
    output logic                             work_pop,
    input  logic [sara_pkg::CELL_SIZE_W-1:0] cell_size,
    output logic                             result_valid,
    input  logic                             result_stall,
    output sara_pkg::result_t                result
);
    import sara_pkg::*;

    localparam int TC_W = COUNT_WIDTH + 1;

    typedef enum logic [4:0] {
        S_IDLE,
        S_C2,
        S_EDGE_P,
        S_EDGE_Q,
        S_EDGE_SQ,
        S_EDGE_RAD,
        S_EDGE_WAIT,
        S_TRI_A,
        S_TRI_B,
        S_TRI_C,
        S_TRI_SUM,
        S_TRI_MUL,
        S_R1_START,
        S_R1_WAIT,
        S_R2_START,
        S_R2_WAIT,
        S_TRI_P,
        S_TRI_ADD,
        S_ACC,
        S_TOTAL,
        S_DIV1,
        S_DIV1_WAIT,
        S_DIV2,
        S_DIV2_WAIT,
        S_OUT
    } back_state_t;

    back_state_t              state_reg;
    logic [3:0]               edge_reg;
    logic [2:0]               tri_reg;
    logic [REGION_SUM_W-1:0]  region_sum_reg;
    logic [REGION_CNT_W-1:0]  region_count_reg;
    logic [TOTAL_SUM_W-1:0]   total_sum_reg;
    logic [COUNT_WIDTH-1:0]   total_count_reg;
    logic [IDX_W-1:0]         ri_reg;
    logic [IDX_W-1:0]         li_reg;
    logic                     result_valid_reg;
    result_t                  result_reg;

    // datapath registers
    work_t                    item_reg;
    logic [C2_W-1:0]          c2_reg;
    logic [HEIGHT_W-1:0]      hp_reg;
    logic [HEIGHT_W-1:0]      d_reg;
    logic [C2_W-1:0]          d2_reg;
    logic [HALF_W-1:0]        half_reg [NUM_EDGES];
    logic [HALF_W-1:0]        ta_reg;
    logic [HALF_W-1:0]        tb_reg;
    logic [HALF_W-1:0]        tc_reg;
    logic [HALF_W+1:0]        x_reg;
    logic [HALF_W:0]          u_reg;
    logic [HALF_W:0]          v_reg;
    logic [HALF_W:0]          w_reg;
    logic [RAD_W-1:0]         xu_reg;
    logic [RAD_W-1:0]         vw_reg;
    logic [ROOT_W-1:0]        r1_reg;
    logic [ROOT_W-1:0]        r2_reg;
    logic [2*ROOT_W-1:0]      p_reg;
    logic [ACC_W-1:0]         acc_reg;

    // combinational helpers
    logic [CELL_SIZE_W-1:0]   cs_eff;
    logic [HEIGHT_W-1:0]      hq;
    logic [C2_W:0]            l2;
    logic [C2_W+1:0]          edge_sum;
    logic [HALF_W:0]          bc;
    logic [HALF_W:0]          ac;
    logic [HALF_W:0]          ab;
    logic [AREA_W-1:0]        area;
    logic [REGION_SUM_W:0]    rs_add;
    logic [TOTAL_SUM_W:0]     ts_add;
    logic [TC_W-1:0]          tc_add;
    logic                     out_free;
    sqrt_req_t                sqrt_req;
    sqrt_rsp_t                sqrt_rsp;
    logic                     div_start;
    logic [TOTAL_SUM_W-1:0]   div_sum;
    logic [COUNT_WIDTH-1:0]   div_count;
    div_rsp_t                 div_rsp;

    assign cs_eff   = (cell_size == '0) ? CELL_SIZE_W'(1) : cell_size;
    assign hq       = item_reg.heights[EDGE_Q[edge_reg]];
    assign l2       = EDGE_DIAG[edge_reg] ? {c2_reg, 1'b0} : {1'b0, c2_reg};
    assign edge_sum = {2'b00, d2_reg} + {1'b0, l2};
    assign bc       = {1'b0, tb_reg} + {1'b0, tc_reg};
    assign ac       = {1'b0, ta_reg} + {1'b0, tc_reg};
    assign ab       = {1'b0, ta_reg} + {1'b0, tb_reg};
    assign area     = acc_reg[ACC_W-1:AREA_SHIFT];
    assign rs_add   = {1'b0, region_sum_reg} + (REGION_SUM_W+1)'(area);
    assign ts_add   = {1'b0, total_sum_reg} + (TOTAL_SUM_W+1)'(region_sum_reg);
    assign tc_add   = {1'b0, total_count_reg} + TC_W'(region_count_reg);
    assign out_free = ~result_valid_reg | ~result_stall;
    assign work_pop = (state_reg == S_IDLE) & work_valid;

    // Root unit requests
    always_comb
    begin
        sqrt_req.start    = (state_reg == S_EDGE_RAD) || (state_reg == S_R1_START)
                         || (state_reg == S_R2_START);
        sqrt_req.radicand = RAD_W'({edge_sum, 4'b0000});
        if (state_reg == S_R1_START)
        begin
            sqrt_req.radicand = xu_reg;
        end
        else if (state_reg == S_R2_START)
        begin
            sqrt_req.radicand = vw_reg;
        end
    end

    // Ratio unit requests
    always_comb
    begin
        div_start = (state_reg == S_DIV1) || (state_reg == S_DIV2);
        div_sum   = total_sum_reg;
        div_count = total_count_reg;
        if (state_reg == S_DIV1)
        begin
            div_sum   = TOTAL_SUM_W'(region_sum_reg);
            div_count = COUNT_WIDTH'(region_count_reg);
        end
    end

    sara_sqrt u_sqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (sqrt_req),
        .rsp   (sqrt_rsp)
    );

    sara_div #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .sum   (div_sum),
        .count (div_count),
        .c2    (c2_reg),
        .rsp   (div_rsp)
    );

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // Sequencer, accumulators and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            edge_reg         <= '0;
            tri_reg          <= '0;
            region_sum_reg   <= '0;
            region_count_reg <= '0;
            total_sum_reg    <= '0;
            total_count_reg  <= '0;
            ri_reg           <= '0;
            li_reg           <= '0;
            result_valid_reg <= 1'b0;
            result_reg       <= '0;
        end
        else
        begin
            // output beat taken; S_OUT reloads it itself
            if (result_valid_reg && !result_stall && (state_reg != S_OUT))
            begin
                result_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (work_valid && (work.full || work.emit))
                    begin
                        state_reg <= S_C2;
                    end
                end
                S_C2:
                begin
                    edge_reg  <= '0;
                    tri_reg   <= '0;
                    state_reg <= item_reg.full ? S_EDGE_P : S_TOTAL;
                end
                S_EDGE_P:    state_reg <= S_EDGE_Q;
                S_EDGE_Q:    state_reg <= S_EDGE_SQ;
                S_EDGE_SQ:   state_reg <= S_EDGE_RAD;
                S_EDGE_RAD:  state_reg <= S_EDGE_WAIT;
                S_EDGE_WAIT:
                begin
                    if (sqrt_rsp.done)
                    begin
                        edge_reg  <= edge_reg + 1'b1;
                        state_reg <= (edge_reg == 4'(NUM_EDGES - 1)) ? S_TRI_A : S_EDGE_P;
                    end
                end
                S_TRI_A:     state_reg <= S_TRI_B;
                S_TRI_B:     state_reg <= S_TRI_C;
                S_TRI_C:     state_reg <= S_TRI_SUM;
                S_TRI_SUM:   state_reg <= S_TRI_MUL;
                S_TRI_MUL:   state_reg <= S_R1_START;
                S_R1_START:  state_reg <= S_R1_WAIT;
                S_R1_WAIT:
                begin
                    if (sqrt_rsp.done)
                    begin
                        state_reg <= S_R2_START;
                    end
                end
                S_R2_START:  state_reg <= S_R2_WAIT;
                S_R2_WAIT:
                begin
                    if (sqrt_rsp.done)
                    begin
                        state_reg <= S_TRI_P;
                    end
                end
                S_TRI_P:     state_reg <= S_TRI_ADD;
                S_TRI_ADD:
                begin
                    tri_reg   <= tri_reg + 1'b1;
                    state_reg <= (tri_reg == 3'(NUM_TRIS - 1)) ? S_ACC : S_TRI_A;
                end
                S_ACC:
                begin
                    // saturating region sums
                    region_sum_reg <= rs_add[REGION_SUM_W] ? '1
                                                           : rs_add[REGION_SUM_W-1:0];
                    if (region_count_reg != '1)
                    begin
                        region_count_reg <= region_count_reg + 1'b1;
                    end
                    state_reg <= item_reg.emit ? S_TOTAL : S_IDLE;
                end
                S_TOTAL:
                begin
                    total_sum_reg   <= ts_add[TOTAL_SUM_W] ? '1 : ts_add[TOTAL_SUM_W-1:0];
                    total_count_reg <= tc_add[COUNT_WIDTH] ? '1 : tc_add[COUNT_WIDTH-1:0];
                    state_reg       <= S_DIV1;
                end
                S_DIV1:      state_reg <= S_DIV1_WAIT;
                S_DIV1_WAIT:
                begin
                    if (div_rsp.done)
                    begin
                        ri_reg    <= div_rsp.index;
                        state_reg <= S_DIV2;
                    end
                end
                S_DIV2:      state_reg <= S_DIV2_WAIT;
                S_DIV2_WAIT:
                begin
                    if (div_rsp.done)
                    begin
                        li_reg    <= div_rsp.index;
                        state_reg <= S_OUT;
                    end
                end
                S_OUT:
                begin
                    if (out_free)
                    begin
                        result_valid_reg           <= 1'b1;
                        result_reg.region_index    <= ri_reg;
                        result_reg.region_pixels   <= region_count_reg;
                        result_reg.landscape_index <= li_reg;
                        result_reg.map_done        <= item_reg.map_end;
                        region_sum_reg             <= '0;
                        region_count_reg           <= '0;
                        if (item_reg.map_end)
                        begin
                            total_sum_reg   <= '0;
                            total_count_reg <= '0;
                        end
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // Window geometry datapath
    always_ff @(posedge clk)
    begin
        if (work_pop)
        begin
            item_reg <= work;
        end
        unique case (state_reg)
            S_C2:
            begin
                c2_reg  <= C2_W'(cs_eff) * C2_W'(cs_eff);
                acc_reg <= '0;
            end
            S_EDGE_P:
            begin
                hp_reg <= item_reg.heights[EDGE_P[edge_reg]];
            end
            S_EDGE_Q:
            begin
                d_reg <= (hp_reg > hq) ? hp_reg - hq : hq - hp_reg;
            end
            S_EDGE_SQ:
            begin
                d2_reg <= C2_W'(d_reg) * C2_W'(d_reg);
            end
            S_EDGE_WAIT:
            begin
                if (sqrt_rsp.done)
                begin
                    half_reg[edge_reg] <= sqrt_rsp.root[HALF_W-1:0];
                end
            end
            S_TRI_A:
            begin
                ta_reg <= half_reg[TRI_A[tri_reg]];
            end
            S_TRI_B:
            begin
                tb_reg <= half_reg[TRI_B[tri_reg]];
            end
            S_TRI_C:
            begin
                tc_reg <= half_reg[TRI_C[tri_reg]];
            end
            S_TRI_SUM:
            begin
                // perimeter and the three clamped side differences
                x_reg <= {1'b0, bc} + (HALF_W+2)'(ta_reg);
                u_reg <= (bc > {1'b0, ta_reg}) ? bc - {1'b0, ta_reg} : '0;
                v_reg <= (ac > {1'b0, tb_reg}) ? ac - {1'b0, tb_reg} : '0;
                w_reg <= (ab > {1'b0, tc_reg}) ? ab - {1'b0, tc_reg} : '0;
            end
            S_TRI_MUL:
            begin
                xu_reg <= RAD_W'(x_reg) * RAD_W'(u_reg);
                vw_reg <= RAD_W'(v_reg) * RAD_W'(w_reg);
            end
            S_R1_WAIT:
            begin
                if (sqrt_rsp.done)
                begin
                    r1_reg <= sqrt_rsp.root;
                end
            end
            S_R2_WAIT:
            begin
                if (sqrt_rsp.done)
                begin
                    r2_reg <= sqrt_rsp.root;
                end
            end
            S_TRI_P:
            begin
                p_reg <= (2*ROOT_W)'(r1_reg) * (2*ROOT_W)'(r2_reg);
            end
            S_TRI_ADD:
            begin
                acc_reg <= acc_reg + ACC_W'(p_reg);
            end
            default:
            begin
            end
        endcase
    end

endmodule

>>> rtl/surface_area_ratio_accumulator.sv
// ----------------------------------------------------------------------------
// surface_area_ratio_accumulator: 3D surface area ratio per region
// A complete window passes 32 roots through one shared root unit; a partial
// window without a region close is popped and dropped while the back end idles.
// A region close forms both indices in turn in the shared ratio unit.
// One window is worked at a time behind a 2-beat queue.
// Reset clears all sums and counts and loads cell_size with 2560.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module surface_area_ratio_accumulator #(
    parameter int COUNT_WIDTH = sara_pkg::COUNT_WIDTH_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             pixel_valid,
    output logic                             pixel_stall,
    input  sara_pkg::pixel_t                 pixel,
    output logic                             result_valid,
    input  logic                             result_stall,
    output sara_pkg::result_t                result,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [sara_pkg::CELL_SIZE_W-1:0] cfg_data
);
    import sara_pkg::*;

    logic [CELL_SIZE_W-1:0] cell_size_reg;
    logic                   work_valid;
    work_t                  work;
    logic                   work_pop;

    // Cell size register
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cell_size_reg <= CELL_SIZE_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            cell_size_reg <= cfg_data;
        end
    end

    sara_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .pixel_valid (pixel_valid),
        .pixel_stall (pixel_stall),
        .pixel       (pixel),
        .work_valid  (work_valid),
        .work        (work),
        .work_pop    (work_pop)
    );

    sara_back #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .work_valid   (work_valid),
        .work         (work),
        .work_pop     (work_pop),
        .cell_size    (cell_size_reg),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule

>>> sim/surface_area_ratio_accumulator_tb.sv
// ----------------------------------------------------------------------------
// surface_area_ratio_accumulator_tb: self-checking bench for the area ratio block
// A directed table and then random windows are pushed through the pixel port.
// Expected region results come from a bit-exact area/ratio predictor, and the
// cell size register is swept between phases. Both sides idle at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module surface_area_ratio_accumulator_tb;
    import sara_pkg::*;

    typedef longint unsigned u64_t;

    localparam logic [MASK_W-1:0] ALL_CELLS = 9'h1FF;
    localparam int DRAIN_WAIT = 4000;    // longer than three complete windows in flight
    localparam int LONG_HOLD  = 4000;
    localparam int NUM_ROWS   = 12;

    typedef struct {
        pixel_t  px;
        bit      typed;
        result_t res;
    } stim_row_t;

    logic    clk;
    logic    rst_n;
    logic    pixel_valid;
    logic    pixel_stall;
    pixel_t  pixel;
    logic    result_valid;
    logic    result_stall;
    result_t result;
    logic    cfg_valid;
    logic    cfg_ready;
    logic [CELL_SIZE_W-1:0] cfg_data;

    // predictor state
    u64_t cell_sz;
    u64_t reg_area;
    u64_t reg_pix;
    u64_t map_area;
    u64_t map_pix;

    result_t   pending_results[$];
    stim_row_t rows[NUM_ROWS];
    int        idle_mode;
    bit        long_hold_go;
    bit        long_hold_done;
    int        err_count;

    surface_area_ratio_accumulator DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .pixel_valid  (pixel_valid),
        .pixel_stall  (pixel_stall),
        .pixel        (pixel),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data)
    );

    always #2 clk = ~clk;

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------
    function automatic u64_t int_sqrt(u64_t v);
        u64_t root;
        u64_t bitv;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > v)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (v >= root + bitv)
            begin
                v    = v - (root + bitv);
                root = (root >> 1) + bitv;
            end
            else
                root = root >> 1;
            bitv = bitv >> 2;
        end
        return root;
    endfunction

    function automatic u64_t clamp_sub(u64_t a, u64_t b);
        return (a > b) ? a - b : 64'd0;
    endfunction

    // surface area of a complete window, in 1/4 raw-unit squares
    function automatic u64_t window_surface(pixel_t p, u64_t cs);
        u64_t h[NUM_CELLS];
        u64_t half[NUM_EDGES];
        u64_t c2, a, b, c, d, l2, acc;
        c2   = cs * cs;
        acc  = 0;
        h[0] = u64_t'(p.height_center);
        h[1] = u64_t'(p.height_north);
        h[2] = u64_t'(p.height_east);
        h[3] = u64_t'(p.height_west);
        h[4] = u64_t'(p.height_south);
        h[5] = u64_t'(p.height_northeast);
        h[6] = u64_t'(p.height_northwest);
        h[7] = u64_t'(p.height_southeast);
        h[8] = u64_t'(p.height_southwest);
        for (int i = 0; i < NUM_EDGES; i++)
        begin
            a = h[EDGE_P[i]];
            b = h[EDGE_Q[i]];
            d = (a > b) ? a - b : b - a;
            l2 = EDGE_DIAG[i] ? 2 * c2 : c2;
            half[i] = int_sqrt(16 * (d * d + l2));
        end
        for (int t = 0; t < NUM_TRIS; t++)
        begin
            a = half[TRI_A[t]];
            b = half[TRI_B[t]];
            c = half[TRI_C[t]];
            acc += int_sqrt((a + b + c) * clamp_sub(b + c, a))
                 * int_sqrt(clamp_sub(a + c, b) * clamp_sub(a + b, c));
        end
        return acc >> AREA_SHIFT;
    endfunction

    function automatic logic [IDX_W-1:0] area_ratio(u64_t sum, u64_t cnt, u64_t cs);
        u64_t c2, q1, r, q, idx;
        if (cnt == 0)
            return '0;
        c2 = cs * cs;
        q1 = sum / c2;
        r  = sum % c2;
        if (q1 >= (64'd1 << 56))
            return 16'hFFFF;
        q   = (q1 << 8) + (r << 8) / c2;
        idx = q / cnt;
        return (idx > 64'hFFFF) ? 16'hFFFF : idx[IDX_W-1:0];
    endfunction

    // advance the model by one pixel; has_res set when a region closes
    function automatic void predict_pixel(pixel_t p, output bit has_res, output result_t r);
        u64_t cs, a;
        u64_t sum_max, cnt_max;
        sum_max = (64'd1 << REGION_SUM_W) - 1;
        cnt_max = (64'd1 << COUNT_WIDTH_DEF) - 1;
        cs = (cell_sz == 0) ? 64'd1 : cell_sz;
        has_res = 0;
        r = '0;
        if (p.valid_mask == ALL_CELLS)
        begin
            a = window_surface(p, cs);
            reg_area = (a > sum_max - reg_area) ? sum_max : reg_area + a;
            if (reg_pix < 64'hFFFF)
                reg_pix++;
        end
        if (!p.region_end && !p.map_end)
            return;
        map_area = (reg_area > ~map_area) ? ~64'd0 : map_area + reg_area;
        map_pix  = (reg_pix > cnt_max - map_pix) ? cnt_max : map_pix + reg_pix;
        has_res = 1;
        r.region_index    = area_ratio(reg_area, reg_pix, cs);
        r.region_pixels   = reg_pix[REGION_CNT_W-1:0];
        r.landscape_index = area_ratio(map_area, map_pix, cs);
        r.map_done        = p.map_end;
        reg_area = 0;
        reg_pix  = 0;
        if (p.map_end)
        begin
            map_area = 0;
            map_pix  = 0;
        end
    endfunction

    // ------------------------------------------------------------------
    // Helpers
    // ------------------------------------------------------------------
    task automatic report_mismatch(string msg);
        err_count++;
        $display("[%0t] MISMATCH %s", $time, msg);
    endtask

    function automatic int idle_pct(bit sender);
        case (idle_mode)
            0: return sender ? 14 : 81;
            1: return sender ? 81 : 14;
            default: return 0;
        endcase
    endfunction

    function automatic pixel_t make_px(logic [15:0] hc, logic [15:0] hn, logic [15:0] he,
                                       logic [15:0] hw, logic [15:0] hs, logic [15:0] hne,
                                       logic [15:0] hnw, logic [15:0] hse, logic [15:0] hsw,
                                       logic [8:0] m, logic re, logic me);
        pixel_t p;
        p = '{hc, hn, he, hw, hs, hne, hnw, hse, hsw, m, re, me};
        return p;
    endfunction

    function automatic pixel_t random_px();
        pixel_t p;
        logic [15:0] base;
        int spread;
        base   = 16'($urandom);
        spread = ($urandom_range(0, 3) == 0) ? 65535 : $urandom_range(0, 512);
        p.height_center    = base;
        p.height_north     = base + 16'($urandom_range(0, spread));
        p.height_east      = base + 16'($urandom_range(0, spread));
        p.height_west      = base - 16'($urandom_range(0, spread));
        p.height_south     = base - 16'($urandom_range(0, spread));
        p.height_northeast = $urandom_range(0, 5) == 0 ? 16'hFFFF
                                                       : base + 16'($urandom_range(0, spread));
        p.height_northwest = base - 16'($urandom_range(0, spread));
        p.height_southeast = $urandom_range(0, 5) == 0 ? 16'h0000
                                                       : base + 16'($urandom_range(0, spread));
        p.height_southwest = 16'($urandom);
        p.valid_mask = ($urandom_range(0, 9) < 7) ? ALL_CELLS : 9'($urandom);
        p.region_end = ($urandom_range(0, 7) == 0);
        p.map_end    = ($urandom_range(0, 29) == 0);
        return p;
    endfunction

    // offer one beat, hold it until accepted, then queue its expectation
    task automatic send_pixel(pixel_t p, bit typed, result_t typed_res);
        bit      has_res;
        result_t r;
        @(negedge clk);
        while ($urandom_range(0, 99) < idle_pct(1))
        begin
            pixel_valid = 0;
            @(negedge clk);
        end
        pixel_valid = 1;
        pixel       = p;
        forever
        begin
            @(posedge clk);
            if (!pixel_stall)
                break;
        end
        predict_pixel(p, has_res, r);
        if (has_res)
            pending_results.push_back(typed ? typed_res : r);
    endtask

    task automatic end_burst();
        @(negedge clk);
        pixel_valid = 0;
    endtask

    task automatic wait_drained();
        end_burst();
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    // register write while idle
    task automatic write_cell_size(logic [CELL_SIZE_W-1:0] v);
        wait_drained();
        repeat (DRAIN_WAIT) @(posedge clk);
        @(negedge clk);
        cfg_valid = 1;
        cfg_data  = v;
        forever
        begin
            @(posedge clk);
            if (cfg_ready)
                break;
        end
        cell_sz = u64_t'(v);
        @(negedge clk);
        cfg_valid = 0;
    endtask

    task automatic random_burst(int n);
        for (int i = 0; i < n; i++)
            send_pixel(random_px(), 0, '0);
    endtask

    // ------------------------------------------------------------------
    // Receiver: random stall at the falling edge, plus one long hold-off
    // ------------------------------------------------------------------
    initial
    begin
        int hold_count;
        hold_count   = 0;
        result_stall = 0;
        forever
        begin
            @(negedge clk);
            if (long_hold_go && !long_hold_done)
            begin
                result_stall = 1;
                hold_count++;
                if (hold_count >= LONG_HOLD)
                    long_hold_done = 1;
            end
            else
                result_stall = ($urandom_range(0, 99) < idle_pct(0));
        end
    end

    // ------------------------------------------------------------------
    // Result checker
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            if (pending_results.size() == 0)
                report_mismatch("result beat with nothing expected");
            else
            begin
                want = pending_results.pop_front();
                if (result.region_index !== want.region_index)
                    report_mismatch($sformatf("region_index %h want %h",
                                    result.region_index, want.region_index));
                if (result.region_pixels !== want.region_pixels)
                    report_mismatch($sformatf("region_pixels %h want %h",
                                    result.region_pixels, want.region_pixels));
                if (result.landscape_index !== want.landscape_index)
                    report_mismatch($sformatf("landscape_index %h want %h",
                                    result.landscape_index, want.landscape_index));
                if (result.map_done !== want.map_done)
                    report_mismatch($sformatf("map_done %b want %b",
                                    result.map_done, want.map_done));
            end
        end
    end

    // ------------------------------------------------------------------
    // Timeout
    // ------------------------------------------------------------------
    initial
    begin
        #40_000_000;
        $display("surface_area_ratio_accumulator_tb: done, errors");
        $finish;
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        clk            = 0;
        rst_n          = 0;
        pixel_valid    = 0;
        pixel          = '0;
        cfg_valid      = 0;
        cfg_data       = '0;
        idle_mode      = 0;
        long_hold_go   = 0;
        long_hold_done = 0;
        err_count      = 0;
        cell_sz        = u64_t'(CELL_SIZE_RESET);
        reg_area       = 0;
        reg_pix        = 0;
        map_area       = 0;
        map_pix        = 0;

        // directed table; typed rows carry an obvious result
        rows[0]  = '{make_px(0, 0, 0, 0, 0, 0, 0, 0, 0, 9'h000, 1, 0), 1, '{0, 0, 0, 0}};
        rows[1]  = '{make_px('1, '1, '1, '1, '1, '1, '1, '1, '1, 9'h1FE, 0, 1), 1, '{0, 0, 0, 1}};
        rows[2]  = '{make_px(0, 0, 0, 0, 0, 0, 0, 0, 0, ALL_CELLS, 0, 0), 0, '0};
        rows[3]  = '{make_px('1, '1, '1, '1, '1, '1, '1, '1, '1, ALL_CELLS, 0, 0), 0, '0};
        rows[4]  = '{make_px(0, '1, 0, '1, 0, '1, 0, '1, 0, ALL_CELLS, 1, 0), 0, '0};
        rows[5]  = '{make_px('1, 0, '1, 0, '1, 0, '1, 0, '1, 9'h0FF, 0, 0), 0, '0};
        rows[6]  = '{make_px(100, 900, 50, 3000, 7, 12, 40000, 1, 2, 9'h1EF, 1, 0), 0, '0};
        rows[7]  = '{make_px('1, 0, 0, 0, 0, 0, 0, 0, 0, ALL_CELLS, 0, 0), 0, '0};
        rows[8]  = '{make_px(16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555,
                              16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555, ALL_CELLS, 1, 1), 0, '0};
        rows[9]  = '{make_px(0, 0, 0, 0, 0, 0, 0, 0, 0, 9'h155, 1, 1), 1, '{0, 0, 0, 1}};
        rows[10] = '{make_px(300, 310, 290, 305, 295, 320, 280, 315, 285, ALL_CELLS, 0, 0), 0, '0};
        rows[11] = '{make_px(300, 301, 299, 300, 300, 302, 298, 300, 300, 9'h0AA, 1, 0), 0, '0};

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1;

        for (int i = 0; i < NUM_ROWS; i++)
            send_pixel(rows[i].px, rows[i].typed, rows[i].res);

        // smallest cell size: steep windows saturate the indices
        write_cell_size(16'd1);
        for (int i = 0; i < 4; i++)
            send_pixel(rows[3 + i].px, 0, '0);
        random_burst(140);

        // largest cell size, other idling balance
        write_cell_size(16'hFFFF);
        idle_mode = 1;
        random_burst(140);

        // zero cell size behaves like one
        write_cell_size(16'd0);
        idle_mode = 2;
        random_burst(60);

        // long receiver hold-off while closing a region every beat
        write_cell_size(16'($urandom_range(1, 65535)));
        long_hold_go = 1;
        for (int i = 0; i < 12; i++)
        begin
            pixel_t p;
            p = random_px();
            p.region_end = 1;
            send_pixel(p, 0, '0);
        end
        wait_drained();

        write_cell_size(CELL_SIZE_RESET);
        random_burst(80);

        wait_drained();
        repeat (DRAIN_WAIT) @(posedge clk);
        if (err_count == 0)
            $display("surface_area_ratio_accumulator_tb: done, clean");
        else
            $display("surface_area_ratio_accumulator_tb: done, errors");
        $finish;
    end

endmodule
